// File: hdl/i2cmbe_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by the top level.
package i2cmbe_pkg;

   localparam int DIV_WIDTH_DEFAULT = 16;
   localparam int HALF_PERIOD_WIDTH = 16;
   localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd249;

   localparam int OPCODE_WIDTH = 3;
   localparam int BYTE_WIDTH   = 8;
   localparam int STEP_WIDTH   = 5;

   localparam int REQ_TDATA_WIDTH = 16;
   localparam int RSP_TDATA_WIDTH = 16;

   localparam logic [STEP_WIDTH-1:0] START_PHASES = 5'd4;
   localparam logic [STEP_WIDTH-1:0] STOP_PHASES  = 5'd2;
   localparam logic [STEP_WIDTH-1:0] BYTE_PHASES  = 5'd18;
   localparam logic [STEP_WIDTH-1:0] ACK_STEP     = 5'd16;
   localparam logic [STEP_WIDTH-1:0] ACK_HI_STEP  = 5'd17;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_STOP  = 3'd4
   } opcode_type;

endpackage

// File: hdl/i2c_master_byte_engine_top.sv
// I2C master byte engine, top level: tick sequencer and result register.
// Depends on i2cmbe_pkg.
//
// Each accepted request item is one bus tick and yields exactly one response item
// with the SCL/SDA drive levels and status after that tick. The sequencer state
// updates in the cycle the item is accepted and the response sits in one output
// register, so a new item is taken every cycle while the response side keeps up.
// Bus speed is set by csr half_period: each phase lasts half_period+1 ticks
// (items). Commands offered while a sequence runs are dropped.
module i2c_master_byte_engine_top #(
   parameter int DIV_WIDTH = i2cmbe_pkg::DIV_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [i2cmbe_pkg::HALF_PERIOD_WIDTH-1:0] csr_wr_data,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // wr_data[7:0], send_ack[8], sda_in[9], zero[15:10]
   input  logic [i2cmbe_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // opcode[2:0]
   input  logic [i2cmbe_pkg::OPCODE_WIDTH-1:0]    req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], rd_data[11:4],
   // ack_received[12], zero[15:13]
   output logic [i2cmbe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import i2cmbe_pkg::*;

   localparam int CMP_WIDTH = (DIV_WIDTH > HALF_PERIOD_WIDTH) ? DIV_WIDTH : HALF_PERIOD_WIDTH;

   logic [HALF_PERIOD_WIDTH-1:0] half_period_ff;
   opcode_type                   cmd_ff, cmd_in;
   logic [STEP_WIDTH-1:0]        step_ff, step_in, step_next;
   logic [DIV_WIDTH-1:0]         div_ff, div_in;
   logic [BYTE_WIDTH-1:0]        shift_ff, shift_in;
   logic                         ack_choice_ff, ack_choice_in;
   logic                         ack_flag_ff, ack_flag_in;
   logic                         scl_ff, scl_in;
   logic                         sda_ff, sda_in_lvl;
   logic [BYTE_WIDTH-1:0]        rd_hold_ff, rd_hold_in;
   logic                         done;
   logic                         enter;
   logic [STEP_WIDTH-1:0]        phases;
   logic                         rsp_tvalid_ff;
   logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata_ff;
   logic                         accept;

   logic [BYTE_WIDTH-1:0] req_wr_data;
   logic                  req_send_ack;
   logic                  req_sda;

   assign req_wr_data  = req_tdata[BYTE_WIDTH-1:0];
   assign req_send_ack = req_tdata[BYTE_WIDTH];
   assign req_sda      = req_tdata[BYTE_WIDTH+1];

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      case (cmd_ff)
         OP_START: phases = START_PHASES;
         OP_STOP:  phases = STOP_PHASES;
         default:  phases = BYTE_PHASES;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      step_in       = step_ff;
      div_in        = div_ff;
      shift_in      = shift_ff;
      ack_choice_in = ack_choice_ff;
      ack_flag_in   = ack_flag_ff;
      scl_in        = scl_ff;
      sda_in_lvl    = sda_ff;
      rd_hold_in    = rd_hold_ff;
      done          = 1'b0;
      enter         = 1'b0;
      step_next     = step_ff + 1'b1;

      if (cmd_ff == OP_NONE) begin
         if (req_tuser == OP_START || req_tuser == OP_WRITE || req_tuser == OP_READ ||
             req_tuser == OP_STOP) begin
            cmd_in  = opcode_type'(req_tuser);
            step_in = '0;
            div_in  = '0;
            if (req_tuser == OP_WRITE) begin
               shift_in = req_wr_data;
            end
            if (req_tuser == OP_READ) begin
               shift_in      = '0;
               ack_choice_in = req_send_ack;
            end
            enter = 1'b1;
         end
      end else if (CMP_WIDTH'(div_ff) >= CMP_WIDTH'(half_period_ff)) begin
         if (cmd_ff == OP_WRITE) begin
            if (step_ff < ACK_STEP && step_ff[0]) begin
               shift_in = {shift_ff[BYTE_WIDTH-2:0], 1'b0};
            end else if (step_ff == ACK_HI_STEP) begin
               ack_flag_in = !req_sda;
            end
         end else if (cmd_ff == OP_READ) begin
            if (step_ff < ACK_STEP && step_ff[0]) begin
               shift_in = {shift_ff[BYTE_WIDTH-2:0], req_sda};
            end
         end
         div_in = '0;
         if (step_next >= phases) begin
            case (cmd_ff)
               OP_STOP: begin
                  sda_in_lvl = 1'b1;
               end
               OP_WRITE: begin
                  scl_in = 1'b0;
               end
               OP_READ: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = 1'b0;
                  rd_hold_in = shift_in;
               end
               default: begin
               end
            endcase
            cmd_in  = OP_NONE;
            step_in = '0;
            done    = 1'b1;
         end else begin
            step_in = step_next;
            enter   = 1'b1;
         end
      end else begin
         div_in = DIV_WIDTH'(div_ff + 1'b1);
      end

      if (enter) begin
         case (cmd_in)
            OP_START: begin
               case (step_in[1:0])
                  2'd0:    sda_in_lvl = 1'b1;
                  2'd1:    scl_in     = 1'b1;
                  2'd2:    sda_in_lvl = 1'b0;
                  default: scl_in     = 1'b0;
               endcase
            end
            OP_STOP: begin
               if (step_in == '0) begin
                  scl_in     = 1'b0;
                  sda_in_lvl = 1'b0;
               end else begin
                  scl_in = 1'b1;
               end
            end
            OP_WRITE, OP_READ: begin
               if (step_in[0]) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
                  if (step_in == ACK_STEP) begin
                     sda_in_lvl = (cmd_in == OP_WRITE) ? 1'b1 : !ack_choice_in;
                  end else begin
                     sda_in_lvl = (cmd_in == OP_WRITE) ? shift_in[BYTE_WIDTH-1] : 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         cmd_ff         <= OP_NONE;
         step_ff        <= '0;
         div_ff         <= '0;
         shift_ff       <= '0;
         ack_choice_ff  <= 1'b0;
         ack_flag_ff    <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         rd_hold_ff     <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_period_ff <= csr_wr_data;
         end
         if (accept) begin
            cmd_ff        <= cmd_in;
            step_ff       <= step_in;
            div_ff        <= div_in;
            shift_ff      <= shift_in;
            ack_choice_ff <= ack_choice_in;
            ack_flag_ff   <= ack_flag_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in_lvl;
            rd_hold_ff    <= rd_hold_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= {3'b000, ack_flag_in, rd_hold_in, done, (cmd_in != OP_NONE),
                          sda_in_lvl, scl_in};
      end
   end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the I2C master byte engine top level.
// Drives bus ticks and commands on the request stream and checks every response item
// against a tick-accurate engine model kept here; depends on i2cmbe_pkg.
`timescale 1ns / 100ps

module tb;
   import i2cmbe_pkg::*;

   typedef struct packed {
      logic [2:0] pad;
      logic       ack_received;
      logic [7:0] rd_data;
      logic       done;
      logic       busy;
      logic       sda;
      logic       scl;
   } bus_status_type;

   typedef struct packed {
      logic                         cfg_en;
      logic [HALF_PERIOD_WIDTH-1:0] cfg_val;
      logic [OPCODE_WIDTH-1:0]      op;
      logic [BYTE_WIDTH-1:0]        wr_byte;
      logic                         ack_bit;
      logic                         sda_bit;
      logic                         typed;
      logic [3:0]                   lvl;      // done, busy, sda, scl
   } tick_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [HALF_PERIOD_WIDTH-1:0] csr_wr_data = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_TDATA_WIDTH-1:0]   req_tdata = '0;
   logic [OPCODE_WIDTH-1:0]      req_tuser = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata;

   bus_status_type bus_status_q [$];
   int unsigned mismatch_count = 0;
   logic        calm = 1'b0;
   logic        valid_up = 1'b0;
   logic        bus_open = 1'b0;

   // engine model state
   opcode_type                   eng_cmd = OP_NONE;
   logic [STEP_WIDTH-1:0]        eng_step = '0;
   logic [DIV_WIDTH_DEFAULT-1:0] eng_div = '0;
   logic [BYTE_WIDTH-1:0]        eng_shift = '0;
   logic                         eng_ack_choice = 1'b0;
   logic                         eng_ack_flag = 1'b0;
   logic                         eng_scl = 1'b1;
   logic                         eng_sda = 1'b1;
   logic [BYTE_WIDTH-1:0]        eng_rd_hold = '0;
   logic [HALF_PERIOD_WIDTH-1:0] eng_half_period = HALF_PERIOD_RESET;

   tick_row_type tick_rows [23] = '{
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b1, 1'b1, 4'b0011},
      '{1'b0, 16'd0,     3'd5,     8'hFF, 1'b1, 1'b0, 1'b1, 4'b0011},
      '{1'b0, 16'd0,     3'd7,     8'h00, 1'b0, 1'b1, 1'b1, 4'b0011},
      '{1'b1, 16'd0,     OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 4'b0111},
      '{1'b0, 16'd0,     OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 4'b0111},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b1, 1'b1, 4'b0101},
      '{1'b0, 16'd0,     OP_READ,  8'h00, 1'b1, 1'b0, 1'b1, 4'b0100},
      '{1'b0, 16'd0,     OP_STOP,  8'h00, 1'b0, 1'b1, 1'b1, 4'b1000},
      '{1'b0, 16'd0,     OP_STOP,  8'h00, 1'b0, 1'b0, 1'b1, 4'b0100},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b1, 1'b1, 4'b0101},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b0, 1'b1, 4'b1011},
      '{1'b1, 16'd65535, OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 4'b0111},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b0, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b1, 1'b0, 4'b0000},
      '{1'b1, 16'd1,     OP_NONE,  8'h00, 1'b0, 1'b0, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b0, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b1, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b0, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b1, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_NONE,  8'h00, 1'b0, 1'b0, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, 4'b0000},
      '{1'b0, 16'd0,     OP_READ,  8'hFF, 1'b1, 1'b0, 1'b0, 4'b0000}
   };

   logic [HALF_PERIOD_WIDTH-1:0] speed_plan [12] = '{
      16'd1, 16'd0, 16'd2, 16'd65535, 16'd3, 16'd0,
      16'd249, 16'd1, 16'd4, 16'd2, 16'd7, 16'd0
   };

   i2c_master_byte_engine_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void apply_phase();
      case (eng_cmd)
         OP_START: begin
            case (eng_step)
               5'd0:    eng_sda = 1'b1;
               5'd1:    eng_scl = 1'b1;
               5'd2:    eng_sda = 1'b0;
               default: eng_scl = 1'b0;
            endcase
         end
         OP_STOP: begin
            if (eng_step == 5'd0) begin
               eng_scl = 1'b0;
               eng_sda = 1'b0;
            end else begin
               eng_scl = 1'b1;
            end
         end
         default: begin
            if (eng_step < ACK_STEP && !eng_step[0]) begin
               eng_scl = 1'b0;
               eng_sda = (eng_cmd == OP_WRITE) ? eng_shift[7] : 1'b1;
            end else if (eng_step == ACK_STEP) begin
               eng_scl = 1'b0;
               eng_sda = (eng_cmd == OP_WRITE) ? 1'b1 : ~eng_ack_choice;
            end else begin
               eng_scl = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic bus_status_type predict_bus_tick(input logic [OPCODE_WIDTH-1:0] op,
                                                       input logic [BYTE_WIDTH-1:0] wr_byte,
                                                       input logic ack_bit, input logic sda_bit);
      bus_status_type        st;
      logic                  done;
      logic [STEP_WIDTH-1:0] total;
      done = 1'b0;
      if (eng_cmd == OP_NONE) begin
         if (op >= OP_START && op <= OP_STOP) begin
            eng_cmd  = opcode_type'(op);
            eng_step = '0;
            eng_div  = '0;
            if (eng_cmd == OP_WRITE) eng_shift = wr_byte;
            if (eng_cmd == OP_READ) begin
               eng_shift      = '0;
               eng_ack_choice = ack_bit;
            end
            apply_phase();
         end
      end else if (eng_div >= eng_half_period) begin
         if (eng_step < ACK_STEP && eng_step[0]) begin
            if (eng_cmd == OP_WRITE) eng_shift = {eng_shift[6:0], 1'b0};
            if (eng_cmd == OP_READ) eng_shift = {eng_shift[6:0], sda_bit};
         end else if (eng_step == ACK_HI_STEP && eng_cmd == OP_WRITE) begin
            eng_ack_flag = ~sda_bit;
         end
         eng_div  = '0;
         eng_step = eng_step + 1'b1;
         total = (eng_cmd == OP_START) ? START_PHASES :
                 (eng_cmd == OP_STOP) ? STOP_PHASES : BYTE_PHASES;
         if (eng_step >= total) begin
            case (eng_cmd)
               OP_STOP:  eng_sda = 1'b1;
               OP_WRITE: eng_scl = 1'b0;
               OP_READ: begin
                  eng_scl     = 1'b0;
                  eng_sda     = 1'b0;
                  eng_rd_hold = eng_shift;
               end
               default: ;
            endcase
            eng_cmd  = OP_NONE;
            eng_step = '0;
            eng_div  = '0;
            done     = 1'b1;
         end else begin
            apply_phase();
         end
      end else begin
         eng_div = eng_div + 1'b1;
      end
      st              = '0;
      st.scl          = eng_scl;
      st.sda          = eng_sda;
      st.busy         = (eng_cmd != OP_NONE);
      st.done         = done;
      st.rd_data      = eng_rd_hold;
      st.ack_received = eng_ack_flag;
      return st;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned seen);
      if (want != seen) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, seen);
      end
   endfunction

   // response side: random stalls unless calm, compare each item against the oldest prediction
   always @(posedge clock) begin
      bus_status_type want;
      bus_status_type seen;
      rsp_tready <= calm || ($urandom_range(0, 99) >= 6);
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = bus_status_type'(rsp_tdata);
         if (bus_status_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response item with none pending, got %h", $realtime, rsp_tdata);
         end else begin
            want = bus_status_q.pop_front();
            check_field("scl_out", want.scl, seen.scl);
            check_field("sda_out", want.sda, seen.sda);
            check_field("busy_res", want.busy, seen.busy);
            check_field("done_res", want.done, seen.done);
            check_field("rd_data", want.rd_data, seen.rd_data);
            check_field("ack_received", want.ack_received, seen.ack_received);
         end
      end
   end

   task automatic lower_valid();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   task automatic drain_results();
      lower_valid();
      while (bus_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_half_period(input logic [HALF_PERIOD_WIDTH-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      eng_half_period = value;
   endtask

   task automatic send_tick(input logic [OPCODE_WIDTH-1:0] op,
                            input logic [BYTE_WIDTH-1:0] wr_byte,
                            input logic ack_bit, input logic sda_bit,
                            input logic typed, input logic [3:0] lvl);
      bus_status_type st;
      if (!calm && $urandom_range(0, 99) < 6) begin
         lower_valid();
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      valid_up = 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, sda_bit, ack_bit, wr_byte};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      st = predict_bus_tick(op, wr_byte, ack_bit, sda_bit);
      if (typed) begin
         st = '0;
         {st.done, st.busy, st.sda, st.scl} = lvl;
      end
      bus_status_q.push_back(st);
   endtask

   initial begin : stimulus
      int unsigned                  seg;
      int unsigned                  n;
      int unsigned                  k;
      int unsigned                  roll;
      logic [OPCODE_WIDTH-1:0]      op;
      logic [HALF_PERIOD_WIDTH-1:0] hp;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (tick_rows[i]) begin
         if (tick_rows[i].cfg_en) write_half_period(tick_rows[i].cfg_val);
         send_tick(tick_rows[i].op, tick_rows[i].wr_byte, tick_rows[i].ack_bit,
                   tick_rows[i].sda_bit, tick_rows[i].typed, tick_rows[i].lvl);
      end

      for (seg = 0; seg < 12; seg++) begin
         hp = (seg == 8) ? 16'($urandom_range(0, 15)) : speed_plan[seg];
         write_half_period(hp);
         calm = (seg == 4);
         n = $urandom_range(130, 190);
         for (k = 0; k < n; k++) begin
            if (eng_cmd == OP_NONE) begin
               roll = $urandom_range(0, 99);
               if (roll < 10) begin
                  op = 3'($urandom_range(0, 7));
               end else if (roll < 25) begin
                  op = OP_NONE;
               end else if (!bus_open) begin
                  op = OP_START;
               end else begin
                  roll = $urandom_range(0, 99);
                  op = (roll < 40) ? OP_WRITE : (roll < 75) ? OP_READ :
                       (roll < 90) ? OP_STOP : OP_START;
               end
               if (op == OP_START) bus_open = 1'b1;
               else if (op == OP_STOP) bus_open = 1'b0;
            end else begin
               op = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(0, 7)) : OP_NONE;
            end
            send_tick(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, 4'b0000);
            if ($urandom_range(0, 99) == 0) drain_results();
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && bus_status_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
